FILE: design/i2c_register_access_master_unit_assert.svh
// Assertion macros used by the sequencer design file.
`ifndef I2C_REGISTER_ACCESS_MASTER_UNIT_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define I2CRAM_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("i2cram assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define I2CRAM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("i2cram assertion failed");

`endif

FILE: design/i2cram_pkg.sv
`default_nettype none

package i2cram_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_GAP   = 8'd1;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;
    localparam logic [7:0] WRITE_GAP_RESET   = 8'd5;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Transfer stage within one transaction.
    localparam logic [1:0] STG_ADDR   = 2'd0;
    localparam logic [1:0] STG_REG    = 2'd1;
    localparam logic [1:0] STG_SECOND = 2'd2;
    localparam logic [1:0] STG_RX     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUS_BUSY = 2'd1;
    localparam logic [1:0] ST_BUS_ERR  = 2'd2;
    localparam logic [1:0] ST_NO_ACK   = 2'd3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_REL, PH_ST_LOW, PH_ST_HOLD,
        PH_TX_LOW, PH_TX_SET, PH_TX_HIGH,
        PH_AK_LOW, PH_AK_REL, PH_AK_HIGH, PH_AK_END,
        PH_RX_LOW, PH_RX_HIGH,
        PH_NA_LOW, PH_NA_REL, PH_NA_HIGH, PH_NA_END,
        PH_SP_LOW, PH_SP_SDA, PH_SP_HIGH, PH_SP_REL,
        PH_GAP, PH_DONE
    } t_phase;

    typedef struct packed {
        logic       start_req;
        logic       req_type;
        logic [6:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [1:0] status;
    } t_res;

    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [7:0] write_gap_ticks;
    } t_cfg;

    // Bus levels on entry to a phase: {scl, sda}.
    function automatic logic [1:0] f_enter_lvl(input t_phase p, input logic scl,
                                               input logic sda, input logic msb);
        logic [1:0] lvl;
        lvl = {scl, sda};
        case (p)
            PH_ST_REL:  lvl = 2'b11;
            PH_ST_LOW:  lvl = 2'b10;
            PH_TX_SET:  lvl = {scl, msb};
            PH_RX_LOW:  lvl = 2'b01;
            PH_TX_LOW, PH_AK_LOW, PH_AK_END, PH_NA_LOW, PH_NA_END, PH_SP_LOW:
                lvl = {1'b0, sda};
            PH_TX_HIGH, PH_AK_HIGH, PH_RX_HIGH, PH_NA_HIGH, PH_SP_HIGH:
                lvl = {1'b1, sda};
            PH_AK_REL, PH_NA_REL, PH_SP_REL:
                lvl = {scl, 1'b1};
            PH_SP_SDA:  lvl = {scl, 1'b0};
            PH_GAP, PH_DONE, PH_IDLE:
                lvl = 2'b11;
            default:    lvl = {scl, sda};
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

FILE: design/i2cram_seq.sv
`default_nettype none

module i2cram_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire i2cram_pkg::t_cfg i_cfg,
    input  wire i2cram_pkg::t_req i_req,
    output i2cram_pkg::t_res     o_res
);
    import i2cram_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_tick, n_tick;
    logic [6:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic [7:0] r_data, n_data;
    logic       r_type, n_type;
    logic [7:0] r_last_read, n_last_read;
    logic [1:0] r_last_status, n_last_status;
    logic [1:0] r_stage, n_stage;
    logic       r_nack, n_nack;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;

    // Next-state logic: one tick of the phase sequencer.
    always_comb begin
        t_phase     tgt;
        logic       go;
        logic       fin;
        logic [1:0] fin_st;
        logic       repeated;
        logic [8:0] limit;
        logic [3:0] bit_inc;
        logic [1:0] lvl;

        n_phase       = r_phase;
        n_bit         = r_bit;
        n_shift       = r_shift;
        n_tick        = r_tick;
        n_dev         = r_dev;
        n_reg         = r_reg;
        n_data        = r_data;
        n_type        = r_type;
        n_last_read   = r_last_read;
        n_last_status = r_last_status;
        n_stage       = r_stage;
        n_nack        = r_nack;
        n_scl         = r_scl;
        n_sda         = r_sda;

        tgt      = PH_IDLE;
        go       = 1'b0;
        fin      = 1'b0;
        fin_st   = ST_OK;
        repeated = (r_type == REQ_READ) && (r_stage == STG_SECOND);
        bit_inc  = r_bit + 4'd1;
        lvl      = 2'b11;

        // The gap may be zero and then ends at once; a zero phase length acts as one.
        if (r_phase == PH_GAP) begin
            limit = {1'b0, i_cfg.write_gap_ticks};
        end else if (i_cfg.phase_ticks == 8'd0) begin
            limit = 9'd1;
        end else begin
            limit = {1'b0, i_cfg.phase_ticks};
        end

        if (i_en) begin
            if (r_phase == PH_IDLE) begin
                if (i_req.start_req) begin
                    n_type  = i_req.req_type;
                    n_dev   = i_req.device_addr;
                    n_reg   = i_req.reg_addr;
                    n_data  = i_req.write_data;
                    n_stage = STG_ADDR;
                    n_nack  = 1'b0;
                    n_bit   = 4'd0;
                    n_shift = 8'd0;
                    tgt     = PH_ST_REL;
                    go      = 1'b1;
                end
            end else if (r_phase == PH_DONE) begin
                tgt = PH_IDLE;
                go  = 1'b1;
            end else if ({1'b0, r_tick} + 9'd1 >= limit) begin
                n_tick = 8'd0;
                go     = 1'b1;
                case (r_phase)
                    PH_ST_REL: begin
                        if (!repeated && !i_req.sda_in) begin
                            fin = 1'b1; fin_st = ST_BUS_BUSY;
                        end else begin
                            tgt = PH_ST_LOW;
                        end
                    end
                    PH_ST_LOW: begin
                        if (!repeated && i_req.sda_in) begin
                            fin = 1'b1; fin_st = ST_BUS_ERR;
                        end else begin
                            tgt = PH_ST_HOLD;
                        end
                    end
                    PH_ST_HOLD: begin
                        n_shift = {r_dev, repeated};
                        n_bit   = 4'd0;
                        tgt     = PH_TX_LOW;
                    end
                    PH_TX_LOW: tgt = PH_TX_SET;
                    PH_TX_SET: tgt = PH_TX_HIGH;
                    PH_TX_HIGH: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit   = bit_inc;
                        tgt     = (bit_inc >= BITS_PER_BYTE) ? PH_AK_LOW : PH_TX_LOW;
                    end
                    PH_AK_LOW: tgt = PH_AK_REL;
                    PH_AK_REL: tgt = PH_AK_HIGH;
                    PH_AK_HIGH: begin
                        // Only the first address byte is checked for an acknowledge.
                        if (r_stage == STG_ADDR && i_req.sda_in) begin
                            n_nack = 1'b1;
                        end
                        tgt = PH_AK_END;
                    end
                    PH_AK_END: begin
                        if (r_nack) begin
                            tgt = PH_SP_LOW;
                        end else if (r_stage == STG_ADDR) begin
                            n_stage = STG_REG;
                            n_shift = r_reg;
                            n_bit   = 4'd0;
                            tgt     = PH_TX_LOW;
                        end else if (r_type == REQ_WRITE) begin
                            if (r_stage == STG_REG) begin
                                n_stage = STG_SECOND;
                                n_shift = r_data;
                                n_bit   = 4'd0;
                                tgt     = PH_TX_LOW;
                            end else begin
                                tgt = PH_SP_LOW;
                            end
                        end else if (r_stage == STG_REG) begin
                            n_stage = STG_SECOND;
                            tgt     = PH_ST_REL;
                        end else begin
                            n_stage = STG_RX;
                            n_shift = 8'd0;
                            n_bit   = 4'd0;
                            tgt     = PH_RX_LOW;
                        end
                    end
                    PH_RX_LOW: tgt = PH_RX_HIGH;
                    PH_RX_HIGH: begin
                        n_shift = {r_shift[6:0], i_req.sda_in};
                        n_bit   = bit_inc;
                        tgt     = (bit_inc >= BITS_PER_BYTE) ? PH_NA_LOW : PH_RX_LOW;
                    end
                    PH_NA_LOW:  tgt = PH_NA_REL;
                    PH_NA_REL:  tgt = PH_NA_HIGH;
                    PH_NA_HIGH: tgt = PH_NA_END;
                    PH_NA_END:  tgt = PH_SP_LOW;
                    PH_SP_LOW:  tgt = PH_SP_SDA;
                    PH_SP_SDA:  tgt = PH_SP_HIGH;
                    PH_SP_HIGH: tgt = PH_SP_REL;
                    PH_SP_REL: begin
                        if (r_nack) begin
                            fin = 1'b1; fin_st = ST_NO_ACK;
                        end else if (r_type == REQ_READ) begin
                            n_last_read = r_shift;
                            fin = 1'b1;
                        end else if (i_cfg.write_gap_ticks != 8'd0) begin
                            tgt = PH_GAP;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    PH_GAP:  fin = 1'b1;
                    default: tgt = PH_IDLE;
                endcase
            end else begin
                n_tick = r_tick + 8'd1;
            end

            if (fin) begin
                n_last_status = fin_st;
                if (r_type == REQ_READ && fin_st != ST_OK) begin
                    n_last_read = 8'd0;
                end
                tgt = PH_DONE;
            end

            if (go) begin
                n_phase = tgt;
                n_tick  = 8'd0;
                lvl     = f_enter_lvl(tgt, r_scl, r_sda, n_shift[7]);
                n_scl   = lvl[1];
                n_sda   = lvl[0];
            end
        end
    end

    // Result of this tick, taken from the updated state.
    always_comb begin
        o_res.scl_out   = n_scl;
        o_res.sda_out   = n_sda;
        o_res.busy_res  = (n_phase != PH_IDLE) && (n_phase != PH_DONE);
        o_res.done_res  = (n_phase == PH_DONE);
        o_res.read_data = n_last_read;
        o_res.status    = n_last_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit         <= 4'd0;
            r_shift       <= 8'd0;
            r_tick        <= 8'd0;
            r_dev         <= 7'd0;
            r_reg         <= 8'd0;
            r_data        <= 8'd0;
            r_type        <= 1'b0;
            r_last_read   <= 8'd0;
            r_last_status <= ST_OK;
            r_stage       <= STG_ADDR;
            r_nack        <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
        end else begin
            r_phase       <= n_phase;
            r_bit         <= n_bit;
            r_shift       <= n_shift;
            r_tick        <= n_tick;
            r_dev         <= n_dev;
            r_reg         <= n_reg;
            r_data        <= n_data;
            r_type        <= n_type;
            r_last_read   <= n_last_read;
            r_last_status <= n_last_status;
            r_stage       <= n_stage;
            r_nack        <= n_nack;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
        end
    end

`include "i2c_register_access_master_unit_assert.svh"

    `I2CRAM_ASSERT_NEXT(a_done_one_tick, (r_phase == PH_DONE) && i_en, r_phase == PH_IDLE)
    `I2CRAM_ASSERT_NEXT(a_idle_holds, (r_phase == PH_IDLE) && i_en && !i_req.start_req, r_phase == PH_IDLE)
    `I2CRAM_ASSERT_NEXT(a_stall_holds, !i_en, $stable(r_phase) && $stable(r_tick) && $stable(r_shift))
    `I2CRAM_ASSERT_NOW(a_bit_range, 1'b1, r_bit <= BITS_PER_BYTE)

endmodule

`default_nettype wire

FILE: design/i2c_register_access_master_unit.sv
// Channel  Direction  Handshake             Payload
// s        in         i_s_tvalid/o_s_tready tdata: device_addr, reg_addr, write_data, sda_in
//                                            tuser: start_req, req_type
// m        out        o_m_tvalid/i_m_tready tdata: scl, sda, busy, done, read_data, status
// cfg      in         i_cfg_valid/o_cfg_ready index 0 phase_ticks, 1 write_gap_ticks
//
// Every accepted word is one bus tick and yields exactly one result word.
// The sequencer steps once per accepted word, so one word per cycle is sustained;
// the output register holds a result while the next word is taken.
// Reset returns the bus to idle with both lines released and both registers at defaults.
// When the output is stalled and full, o_s_tready drops and the sequencer holds.
`default_nettype none

module i2c_register_access_master_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // tdata bits from low: device_addr[6:0], reg_addr[14:7], write_data[22:15], sda_in[23]
    input  wire logic [i2cram_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // tuser bits from low: start_req[0], req_type[1]
    input  wire logic [i2cram_pkg::IN_USER_W-1:0]   i_s_tuser,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata bits from low: scl_out[0], sda_out[1], busy_res[2], done_res[3],
    // read_data[11:4], status[13:12], zero[15:14]
    output logic [i2cram_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [i2cram_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [i2cram_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import i2cram_pkg::*;

    t_cfg r_cfg;
    t_req req;
    t_res res;
    logic accept;
    logic r_out_valid;
    t_res r_out;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;

    assign req.start_req   = i_s_tuser[0];
    assign req.req_type    = i_s_tuser[1];
    assign req.device_addr = i_s_tdata[6:0];
    assign req.reg_addr    = i_s_tdata[14:7];
    assign req.write_data  = i_s_tdata[22:15];
    assign req.sda_in      = i_s_tdata[23];

    i2cram_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_cfg   (r_cfg),
        .i_req   (req),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks     <= PHASE_TICKS_RESET;
            r_cfg.write_gap_ticks <= WRITE_GAP_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PHASE_TICKS) begin
                r_cfg.phase_ticks <= i_cfg_data;
            end else if (i_cfg_index == CFG_WRITE_GAP) begin
                r_cfg.write_gap_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.status, r_out.read_data, r_out.done_res,
                         r_out.busy_res, r_out.sda_out, r_out.scl_out};

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import i2cram_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } t_tick_row;

    typedef struct {
        logic [7:0] phase_ticks;
        logic [7:0] gap_ticks;
        int         idle_pct;
        int         stall_pct;
        int         ticks;
    } t_run_plan;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic [IN_USER_W-1:0]  i_s_tuser   = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    i2c_register_access_master_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bus sequencer state as the testbench expects it.
    t_phase     bus_phase;
    logic [3:0] bus_bit;
    logic [7:0] bus_shift;
    logic [7:0] bus_count;
    logic [6:0] bus_dev;
    logic [7:0] bus_reg;
    logic [7:0] bus_data;
    logic       bus_type;
    logic [7:0] bus_read;
    logic [1:0] bus_status;
    logic [1:0] bus_stage;
    logic       bus_nack;
    logic       bus_scl;
    logic       bus_sda;
    logic [7:0] reg_phase_ticks;
    logic [7:0] reg_write_gap;

    t_res expected_levels[$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   idle_pct       = 0;
    int   stall_pct      = 0;

    function automatic void bus_enter(input t_phase p);
        bus_phase = p;
        bus_count = '0;
        case (p)
            PH_ST_REL: begin
                bus_scl = 1'b1;
                bus_sda = 1'b1;
            end
            PH_ST_LOW: begin
                bus_scl = 1'b1;
                bus_sda = 1'b0;
            end
            PH_TX_SET: bus_sda = bus_shift[7];
            PH_RX_LOW: begin
                bus_scl = 1'b0;
                bus_sda = 1'b1;
            end
            PH_TX_LOW, PH_AK_LOW, PH_AK_END, PH_NA_LOW, PH_NA_END, PH_SP_LOW:
                bus_scl = 1'b0;
            PH_TX_HIGH, PH_AK_HIGH, PH_RX_HIGH, PH_NA_HIGH, PH_SP_HIGH:
                bus_scl = 1'b1;
            PH_AK_REL, PH_NA_REL, PH_SP_REL:
                bus_sda = 1'b1;
            PH_SP_SDA: bus_sda = 1'b0;
            PH_GAP, PH_DONE, PH_IDLE: begin
                bus_scl = 1'b1;
                bus_sda = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void bus_close(input logic [1:0] code);
        bus_status = code;
        if (bus_type == REQ_READ && code != ST_OK)
            bus_read = '0;
        bus_enter(PH_DONE);
    endfunction

    function automatic void bus_load(input logic [7:0] b);
        bus_shift = b;
        bus_bit   = '0;
        bus_enter(PH_TX_LOW);
    endfunction

    function automatic void bus_phase_end(input logic sda);
        logic repeated;
        repeated = (bus_type == REQ_READ) && (bus_stage == STG_SECOND);
        case (bus_phase)
            PH_ST_REL: begin
                if (!repeated && !sda) bus_close(ST_BUS_BUSY);
                else bus_enter(PH_ST_LOW);
            end
            PH_ST_LOW: begin
                if (!repeated && sda) bus_close(ST_BUS_ERR);
                else bus_enter(PH_ST_HOLD);
            end
            PH_ST_HOLD: bus_load({bus_dev, repeated});
            PH_TX_LOW:  bus_enter(PH_TX_SET);
            PH_TX_SET:  bus_enter(PH_TX_HIGH);
            PH_TX_HIGH: begin
                bus_shift = {bus_shift[6:0], 1'b0};
                bus_bit   = bus_bit + 4'd1;
                if (bus_bit >= BITS_PER_BYTE) bus_enter(PH_AK_LOW);
                else bus_enter(PH_TX_LOW);
            end
            PH_AK_LOW:  bus_enter(PH_AK_REL);
            PH_AK_REL:  bus_enter(PH_AK_HIGH);
            PH_AK_HIGH: begin
                // Only the first address byte is held to its acknowledge.
                if (bus_stage == STG_ADDR && sda) bus_nack = 1'b1;
                bus_enter(PH_AK_END);
            end
            PH_AK_END: begin
                if (bus_nack) begin
                    bus_enter(PH_SP_LOW);
                end else if (bus_stage == STG_ADDR) begin
                    bus_stage = STG_REG;
                    bus_load(bus_reg);
                end else if (bus_type == REQ_WRITE) begin
                    if (bus_stage == STG_REG) begin
                        bus_stage = STG_SECOND;
                        bus_load(bus_data);
                    end else begin
                        bus_enter(PH_SP_LOW);
                    end
                end else if (bus_stage == STG_REG) begin
                    bus_stage = STG_SECOND;
                    bus_enter(PH_ST_REL);
                end else begin
                    bus_stage = STG_RX;
                    bus_shift = '0;
                    bus_bit   = '0;
                    bus_enter(PH_RX_LOW);
                end
            end
            PH_RX_LOW:  bus_enter(PH_RX_HIGH);
            PH_RX_HIGH: begin
                bus_shift = {bus_shift[6:0], sda};
                bus_bit   = bus_bit + 4'd1;
                if (bus_bit >= BITS_PER_BYTE) bus_enter(PH_NA_LOW);
                else bus_enter(PH_RX_LOW);
            end
            PH_NA_LOW:  bus_enter(PH_NA_REL);
            PH_NA_REL:  bus_enter(PH_NA_HIGH);
            PH_NA_HIGH: bus_enter(PH_NA_END);
            PH_NA_END:  bus_enter(PH_SP_LOW);
            PH_SP_LOW:  bus_enter(PH_SP_SDA);
            PH_SP_SDA:  bus_enter(PH_SP_HIGH);
            PH_SP_HIGH: bus_enter(PH_SP_REL);
            PH_SP_REL: begin
                if (bus_nack) begin
                    bus_close(ST_NO_ACK);
                end else if (bus_type == REQ_READ) begin
                    bus_read = bus_shift;
                    bus_close(ST_OK);
                end else if (reg_write_gap != 8'd0) begin
                    bus_enter(PH_GAP);
                end else begin
                    bus_close(ST_OK);
                end
            end
            PH_GAP:  bus_close(ST_OK);
            default: bus_enter(PH_IDLE);
        endcase
    endfunction

    function automatic t_res predict_bus_tick(input t_req r);
        int   lim;
        t_res o;
        if (bus_phase == PH_IDLE) begin
            if (r.start_req) begin
                bus_type  = r.req_type;
                bus_dev   = r.device_addr;
                bus_reg   = r.reg_addr;
                bus_data  = r.write_data;
                bus_stage = STG_ADDR;
                bus_nack  = 1'b0;
                bus_bit   = '0;
                bus_shift = '0;
                bus_enter(PH_ST_REL);
            end
        end else if (bus_phase == PH_DONE) begin
            bus_enter(PH_IDLE);
        end else begin
            lim = (bus_phase == PH_GAP) ? int'(reg_write_gap) : int'(reg_phase_ticks);
            if (lim == 0 && bus_phase != PH_GAP) lim = 1;
            if (int'(bus_count) + 1 >= lim) begin
                bus_count = '0;
                bus_phase_end(r.sda_in);
            end else begin
                bus_count = bus_count + 8'd1;
            end
        end
        o.scl_out   = bus_scl;
        o.sda_out   = bus_sda;
        o.busy_res  = (bus_phase != PH_IDLE) && (bus_phase != PH_DONE);
        o.done_res  = (bus_phase == PH_DONE);
        o.read_data = bus_read;
        o.status    = bus_status;
        return o;
    endfunction

    // Mostly a cooperative target: free bus at start, address acknowledged most
    // of the time, random read bits. A small share of ticks is pure noise.
    function automatic logic pick_sda();
        logic repeated;
        repeated = (bus_type == REQ_READ) && (bus_stage == STG_SECOND);
        if ($urandom_range(99) < 8) return 1'($urandom);
        case (bus_phase)
            PH_ST_REL:  return repeated ? 1'($urandom) : 1'b1;
            PH_ST_LOW:  return repeated ? 1'($urandom) : 1'b0;
            PH_AK_HIGH: return (bus_stage == STG_ADDR) ? ($urandom_range(99) < 20)
                                                       : 1'($urandom);
            default:    return 1'($urandom);
        endcase
    endfunction

    task automatic send_tick(input t_req r, input bit typed, input t_res want);
        int   gap = 0;
        t_res next;
        while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {r.sda_in, r.write_data, r.reg_addr, r.device_addr};
        i_s_tuser  <= {r.req_type, r.start_req};
        do @(posedge i_clk); while (!o_s_tready);
        next = predict_bus_tick(r);
        expected_levels.push_back(typed ? want : next);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_levels.size() != 0);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PHASE_TICKS) reg_phase_ticks = val;
        else if (idx == CFG_WRITE_GAP) reg_write_gap = val;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        t_res got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.scl_out   = o_m_tdata[0];
            got.sda_out   = o_m_tdata[1];
            got.busy_res  = o_m_tdata[2];
            got.done_res  = o_m_tdata[3];
            got.read_data = o_m_tdata[11:4];
            got.status    = o_m_tdata[13:12];
            if (expected_levels.size() == 0) begin
                $error("result word %h with nothing expected", o_m_tdata);
                mismatch_count++;
            end else begin
                want = expected_levels.pop_front();
                check_field("scl_out", int'(want.scl_out), int'(got.scl_out));
                check_field("sda_out", int'(want.sda_out), int'(got.sda_out));
                check_field("busy_res", int'(want.busy_res), int'(got.busy_res));
                check_field("done_res", int'(want.done_res), int'(got.done_res));
                check_field("read_data", int'(want.read_data), int'(got.read_data));
                check_field("status", int'(want.status), int'(got.status));
            end
        end
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        t_tick_row rows[$];
        t_run_plan plans[$];
        t_req      r;

        bus_phase       = PH_IDLE;
        bus_bit         = '0;
        bus_shift       = '0;
        bus_count       = '0;
        bus_dev         = '0;
        bus_reg         = '0;
        bus_data        = '0;
        bus_type        = REQ_WRITE;
        bus_read        = '0;
        bus_status      = ST_OK;
        bus_stage       = STG_ADDR;
        bus_nack        = 1'b0;
        bus_scl         = 1'b1;
        bus_sda         = 1'b1;
        reg_phase_ticks = PHASE_TICKS_RESET;
        reg_write_gap   = WRITE_GAP_RESET;

        // Released lines and idle status after reset, with quiet and all-ones fields.
        rows.push_back('{'{1'b0, REQ_WRITE, 7'd0, 8'd0, 8'd0, 1'b0}, 1'b1,
                         '{1'b1, 1'b1, 1'b0, 1'b0, 8'd0, ST_OK}});
        rows.push_back('{'{1'b0, REQ_READ, 7'd127, 8'd255, 8'd255, 1'b1}, 1'b1,
                         '{1'b1, 1'b1, 1'b0, 1'b0, 8'd0, ST_OK}});
        // Write request meets a bus held low: busy, no stop.
        rows.push_back('{'{1'b1, REQ_WRITE, 7'd127, 8'd255, 8'd255, 1'b0}, 1'b1,
                         '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0, ST_OK}});
        rows.push_back('{'{1'b0, REQ_WRITE, 7'd0, 8'd0, 8'd0, 1'b0}, 1'b1,
                         '{1'b1, 1'b1, 1'b0, 1'b1, 8'd0, ST_BUS_BUSY}});
        // A request on the done word is dropped.
        rows.push_back('{'{1'b1, REQ_READ, 7'd1, 8'd2, 8'd3, 1'b0}, 1'b1,
                         '{1'b1, 1'b1, 1'b0, 1'b0, 8'd0, ST_BUS_BUSY}});
        // Read request where SDA never follows the start low: bus error.
        rows.push_back('{'{1'b1, REQ_READ, 7'd0, 8'd0, 8'd0, 1'b1}, 1'b1,
                         '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0, ST_BUS_BUSY}});
        rows.push_back('{'{1'b0, REQ_WRITE, 7'd0, 8'd0, 8'd0, 1'b1}, 1'b1,
                         '{1'b1, 1'b0, 1'b1, 1'b0, 8'd0, ST_BUS_BUSY}});
        rows.push_back('{'{1'b0, REQ_WRITE, 7'd0, 8'd0, 8'd0, 1'b1}, 1'b1,
                         '{1'b1, 1'b1, 1'b0, 1'b1, 8'd0, ST_BUS_ERR}});
        rows.push_back('{'{1'b0, REQ_WRITE, 7'd0, 8'd0, 8'd0, 1'b1}, 1'b1,
                         '{1'b1, 1'b1, 1'b0, 1'b0, 8'd0, ST_BUS_ERR}});
        // A clean start; the random part carries the transfer on from here.
        rows.push_back('{'{1'b1, REQ_WRITE, 7'h2A, 8'hA5, 8'h5A, 1'b1}, 1'b0, '0});
        rows.push_back('{'{1'b0, REQ_READ, 7'h55, 8'h5A, 8'hA5, 1'b1}, 1'b0, '0});
        rows.push_back('{'{1'b1, REQ_READ, 7'h7F, 8'h00, 8'hFF, 1'b0}, 1'b0, '0});

        plans.push_back('{8'd1, 8'd5, 0, 0, 60});
        plans.push_back('{8'd0, 8'd0, 46, 0, 60});
        plans.push_back('{8'd2, 8'd1, 0, 46, 60});
        plans.push_back('{8'd1, 8'd255, 19, 19, 80});
        plans.push_back('{8'd255, 8'd0, 19, 19, 70});
        plans.push_back('{8'd3, 8'd2, 0, 0, 60});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_tick(rows[i].req, rows[i].typed, rows[i].want);

        foreach (plans[p]) begin
            // Hold the sender until every word is back before touching registers.
            drain_results();
            if (p == 1) begin
                write_reg(8'd2, 8'd7);
                write_reg(8'hFF, 8'd0);
            end
            write_reg(CFG_PHASE_TICKS, plans[p].phase_ticks);
            write_reg(CFG_WRITE_GAP, plans[p].gap_ticks);
            idle_pct  = plans[p].idle_pct;
            stall_pct = plans[p].stall_pct;
            repeat (plans[p].ticks) begin
                r.start_req   = (bus_phase == PH_IDLE) ? ($urandom_range(99) < 70)
                                                       : ($urandom_range(99) < 5);
                r.req_type    = 1'($urandom);
                r.device_addr = 7'($urandom);
                r.reg_addr    = 8'($urandom);
                r.write_data  = 8'($urandom);
                r.sda_in      = pick_sda();
                send_tick(r, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: i2c_register_access_master_unit.f
+incdir+design
design/i2cram_pkg.sv
design/i2cram_seq.sv
design/i2c_register_access_master_unit.sv
dv/testbench.sv
